/* rtl/core/utf8sc_pkg.sv */
package utf8sc_pkg;

    // Class codes carried in the low bits of the result beat.
    localparam logic [2:0] CLS_NONE     = 3'd0;
    localparam logic [2:0] CLS_LATIN    = 3'd1;
    localparam logic [2:0] CLS_CYR      = 3'd2;
    localparam logic [2:0] CLS_OTHER    = 3'd3;
    localparam logic [2:0] CLS_SP_LATIN = 3'd4;
    localparam logic [2:0] CLS_SP_CYR   = 3'd5;
    localparam logic [2:0] CLS_SP_OTHER = 3'd6;

    // Pending Cyrillic lead byte.
    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_D0   = 2'd1;
    localparam logic [1:0] LEAD_D1   = 2'd2;

    // Byte values used by the scan.
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
    localparam logic [7:0] BYTE_LOWER_A = 8'h61;
    localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;
    localparam logic [7:0] BYTE_D0      = 8'hD0;
    localparam logic [7:0] BYTE_D1      = 8'hD1;
    localparam logic [7:0] BYTE_80      = 8'h80;
    localparam logic [7:0] BYTE_81      = 8'h81;
    localparam logic [7:0] BYTE_8F      = 8'h8F;
    localparam logic [7:0] BYTE_90      = 8'h90;
    localparam logic [7:0] BYTE_91      = 8'h91;
    localparam logic [7:0] BYTE_BF      = 8'hBF;
    localparam logic [7:0] BYTE_C3      = 8'hC3;
    localparam logic [7:0] BYTE_E3      = 8'hE3;
    localparam logic [7:0] BYTE_F0      = 8'hF0;

    // Result beat layout, highest bits first.
    typedef struct packed {
        logic [1:0] pad;
        logic       other_seen;
        logic       cyrillic_seen;
        logic       latin_seen;
        logic [2:0] class_code;
    } result_t;

    // A leading space selects the space codes; other beats Latin, Latin beats Cyrillic.
    function automatic logic [2:0] class_of(input logic sp, input logic lat,
                                            input logic cyr, input logic frn);
        logic [2:0] code;
        code = CLS_NONE;
        if (sp && frn)
            code = CLS_SP_OTHER;
        else if (sp && lat)
            code = CLS_SP_LATIN;
        else if (sp && cyr)
            code = CLS_SP_CYR;
        else if (frn)
            code = CLS_OTHER;
        else if (lat)
            code = CLS_LATIN;
        else if (cyr)
            code = CLS_CYR;
        return code;
    endfunction

endpackage

/* rtl/core/utf8_script_classifier.sv */
// Script classifier for short UTF-8 text pieces.
// The slave channel takes one byte of the piece per beat in s_axis_tdata, with
// s_axis_tlast high on the final byte; an empty piece is never sent. Only the final
// byte produces a beat on the master channel: the class code and the three seen flags.
// Each byte is first captured in an input register, then scanned by combinational logic
// against the per-piece state (leading space, seen flags, pending lead, skip count).
// One byte is taken every cycle unless a final byte waits for room at the output;
// the scan lies between the input register and the state and result registers.
// The final byte's result is registered when that byte leaves the input register.
// After the final byte the scan state returns to its start values, so the next
// piece can follow in the very next cycle.
// When the receiver stalls, the result is held in the output register and bytes
// that end no piece keep flowing; a further final byte waits in the input register,
// and s_axis_tready drops only then.
// Reset restarts the scan and clears both valid flags; no result is pending after reset.
module utf8_script_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] class_code, [3] latin_seen,
                                       // [4] cyrillic_seen, [5] other_seen, [7:6] zero
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       at_first_reg,  at_first_next;
    logic       space_lead_reg, space_lead_next;
    logic       latin_reg,     latin_next;
    logic       cyr_reg,       cyr_next;
    logic       foreign_reg,   foreign_next;
    logic [1:0] lead_reg,      lead_next;
    logic [1:0] skip_reg,      skip_next;

    logic                 out_valid_reg;
    utf8sc_pkg::result_t  out_data_reg;
    utf8sc_pkg::result_t  result;

    logic out_free;
    logic advance;

    logic       sp_new;
    logic       lat_new;
    logic       cyr_new;
    logic       frn_new;
    logic [1:0] lead_new;
    logic [1:0] skip_new;

    // A byte that ends no piece needs no room at the output.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        sp_new   = at_first_reg ? (in_byte_reg == utf8sc_pkg::BYTE_SPACE) : space_lead_reg;
        lat_new  = latin_reg;
        cyr_new  = cyr_reg;
        frn_new  = foreign_reg;
        lead_new = lead_reg;
        skip_new = skip_reg;

        if (skip_reg != 2'd0)
        begin
            skip_new = skip_reg - 2'd1;
        end
        else if (lead_reg == utf8sc_pkg::LEAD_D0)
        begin
            lead_new = utf8sc_pkg::LEAD_NONE;
            if ((in_byte_reg >= utf8sc_pkg::BYTE_90 && in_byte_reg <= utf8sc_pkg::BYTE_BF)
                || in_byte_reg == utf8sc_pkg::BYTE_81)
                cyr_new = 1'b1;
            else
                frn_new = 1'b1;
        end
        else if (lead_reg != utf8sc_pkg::LEAD_NONE)
        begin
            lead_new = utf8sc_pkg::LEAD_NONE;
            if ((in_byte_reg >= utf8sc_pkg::BYTE_80 && in_byte_reg <= utf8sc_pkg::BYTE_8F)
                || in_byte_reg == utf8sc_pkg::BYTE_91)
                cyr_new = 1'b1;
            else
                frn_new = 1'b1;
        end
        else if ((in_byte_reg >= utf8sc_pkg::BYTE_UPPER_A
                  && in_byte_reg <= utf8sc_pkg::BYTE_UPPER_Z)
                 || (in_byte_reg >= utf8sc_pkg::BYTE_LOWER_A
                  && in_byte_reg <= utf8sc_pkg::BYTE_LOWER_Z))
        begin
            lat_new = 1'b1;
        end
        else if (in_byte_reg[7])
        begin
            // A lone D0 or D1 as the final byte falls through to the two-byte rule.
            if ((in_byte_reg == utf8sc_pkg::BYTE_D0 || in_byte_reg == utf8sc_pkg::BYTE_D1)
                && !in_last_reg)
            begin
                lead_new = (in_byte_reg == utf8sc_pkg::BYTE_D0) ? utf8sc_pkg::LEAD_D0
                                                                : utf8sc_pkg::LEAD_D1;
            end
            else if (in_byte_reg >= utf8sc_pkg::BYTE_C3 && in_byte_reg < utf8sc_pkg::BYTE_E3)
            begin
                frn_new  = 1'b1;
                skip_new = 2'd1;
            end
            else if (in_byte_reg >= utf8sc_pkg::BYTE_E3 && in_byte_reg < utf8sc_pkg::BYTE_F0)
            begin
                frn_new  = 1'b1;
                skip_new = 2'd2;
            end
            else if (in_byte_reg >= utf8sc_pkg::BYTE_F0)
            begin
                skip_new = 2'd3;
            end
        end

        result.pad           = 2'b00;
        result.class_code    = utf8sc_pkg::class_of(sp_new, lat_new, cyr_new, frn_new);
        result.latin_seen    = lat_new;
        result.cyrillic_seen = cyr_new;
        result.other_seen    = frn_new;

        at_first_next   = at_first_reg;
        space_lead_next = space_lead_reg;
        latin_next      = latin_reg;
        cyr_next        = cyr_reg;
        foreign_next    = foreign_reg;
        lead_next       = lead_reg;
        skip_next       = skip_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                at_first_next   = 1'b1;
                space_lead_next = 1'b0;
                latin_next      = 1'b0;
                cyr_next        = 1'b0;
                foreign_next    = 1'b0;
                lead_next       = utf8sc_pkg::LEAD_NONE;
                skip_next       = 2'd0;
            end
            else
            begin
                at_first_next   = 1'b0;
                space_lead_next = sp_new;
                latin_next      = lat_new;
                cyr_next        = cyr_new;
                foreign_next    = frn_new;
                lead_next       = lead_new;
                skip_next       = skip_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            at_first_reg   <= 1'b1;
            space_lead_reg <= 1'b0;
            latin_reg      <= 1'b0;
            cyr_reg        <= 1'b0;
            foreign_reg    <= 1'b0;
            lead_reg       <= utf8sc_pkg::LEAD_NONE;
            skip_reg       <= 2'd0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            at_first_reg   <= at_first_next;
            space_lead_reg <= space_lead_next;
            latin_reg      <= latin_next;
            cyr_reg        <= cyr_next;
            foreign_reg    <= foreign_next;
            lead_reg       <= lead_next;
            skip_reg       <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
            out_data_reg <= result;
    end

    // A skip count and a pending lead byte are never active together.
    a_skip_lead_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(skip_reg != 2'd0 && lead_reg != utf8sc_pkg::LEAD_NONE))
        else $error("skip count and pending lead both active");

    a_lead_code: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg == utf8sc_pkg::LEAD_NONE || lead_reg == utf8sc_pkg::LEAD_D0
        || lead_reg == utf8sc_pkg::LEAD_D1)
        else $error("invalid pending lead code");

    // The scan state starts afresh after the final byte of a piece.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (at_first_reg && !latin_reg && !cyr_reg
                                      && !foreign_reg && skip_reg == 2'd0))
        else $error("state not cleared after final byte");

    // A result without any script class must not report a seen flag.
    a_none_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.class_code == utf8sc_pkg::CLS_NONE)
            |-> !(out_data_reg.latin_seen || out_data_reg.cyrillic_seen
                  || out_data_reg.other_seen))
        else $error("class none with a seen flag set");

endmodule

/* tb/utf8sc_checker.sv */
module utf8sc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    output int         mismatches,
    output int         results_due,
    output int         pieces_checked,
    output logic [6:0] codes_hit
);

    timeunit 1ns;
    timeprecision 1ps;

    // Scan state of the piece currently arriving.
    logic       first_byte;
    logic       lead_space;
    logic       saw_latin;
    logic       saw_cyr;
    logic       saw_other;
    logic [1:0] lead_kind;
    logic [1:0] skip_cnt;

    utf8sc_pkg::result_t class_results_due[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("[%0t] MISMATCH piece %0d: %s got %0d, expected %0d",
                     $realtime, pieces_checked, what, got, want);
        mismatches++;
    endtask

    task automatic clear_scan();
        first_byte = 1'b1;
        lead_space = 1'b0;
        saw_latin  = 1'b0;
        saw_cyr    = 1'b0;
        saw_other  = 1'b0;
        lead_kind  = utf8sc_pkg::LEAD_NONE;
        skip_cnt   = 2'd0;
    endtask

    // Advance the scan by one byte; the final byte of a piece yields its class.
    task automatic scan_text_byte(input logic [7:0] b, input logic fin);
        utf8sc_pkg::result_t verdict;
        if (first_byte)
        begin
            lead_space = (b == utf8sc_pkg::BYTE_SPACE);
            first_byte = 1'b0;
        end
        if (skip_cnt != 2'd0)
            skip_cnt = skip_cnt - 2'd1;
        else if (lead_kind == utf8sc_pkg::LEAD_D0)
        begin
            lead_kind = utf8sc_pkg::LEAD_NONE;
            if ((b >= utf8sc_pkg::BYTE_90 && b <= utf8sc_pkg::BYTE_BF)
                || b == utf8sc_pkg::BYTE_81)
                saw_cyr = 1'b1;
            else
                saw_other = 1'b1;
        end
        else if (lead_kind != utf8sc_pkg::LEAD_NONE)
        begin
            lead_kind = utf8sc_pkg::LEAD_NONE;
            if ((b >= utf8sc_pkg::BYTE_80 && b <= utf8sc_pkg::BYTE_8F)
                || b == utf8sc_pkg::BYTE_91)
                saw_cyr = 1'b1;
            else
                saw_other = 1'b1;
        end
        else if ((b >= utf8sc_pkg::BYTE_UPPER_A && b <= utf8sc_pkg::BYTE_UPPER_Z) ||
                 (b >= utf8sc_pkg::BYTE_LOWER_A && b <= utf8sc_pkg::BYTE_LOWER_Z))
            saw_latin = 1'b1;
        else if (b < utf8sc_pkg::BYTE_80)
            ;
        else if ((b == utf8sc_pkg::BYTE_D0 || b == utf8sc_pkg::BYTE_D1) && !fin)
            lead_kind = (b == utf8sc_pkg::BYTE_D0) ? utf8sc_pkg::LEAD_D0
                                                   : utf8sc_pkg::LEAD_D1;
        else if (b >= utf8sc_pkg::BYTE_C3 && b < utf8sc_pkg::BYTE_E3)
        begin
            saw_other = 1'b1;
            skip_cnt  = 2'd1;
        end
        else if (b >= utf8sc_pkg::BYTE_E3 && b < utf8sc_pkg::BYTE_F0)
        begin
            saw_other = 1'b1;
            skip_cnt  = 2'd2;
        end
        else if (b >= utf8sc_pkg::BYTE_F0)
            skip_cnt = 2'd3;

        if (fin)
        begin
            verdict = '0;
            if (lead_space && saw_other)
                verdict.class_code = utf8sc_pkg::CLS_SP_OTHER;
            else if (lead_space && saw_latin)
                verdict.class_code = utf8sc_pkg::CLS_SP_LATIN;
            else if (lead_space && saw_cyr)
                verdict.class_code = utf8sc_pkg::CLS_SP_CYR;
            else if (saw_other)
                verdict.class_code = utf8sc_pkg::CLS_OTHER;
            else if (saw_latin)
                verdict.class_code = utf8sc_pkg::CLS_LATIN;
            else if (saw_cyr)
                verdict.class_code = utf8sc_pkg::CLS_CYR;
            else
                verdict.class_code = utf8sc_pkg::CLS_NONE;
            verdict.latin_seen    = saw_latin;
            verdict.cyrillic_seen = saw_cyr;
            verdict.other_seen    = saw_other;
            codes_hit[verdict.class_code] = 1'b1;
            class_results_due.push_back(verdict);
            clear_scan();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf8sc_pkg::result_t got;
        utf8sc_pkg::result_t want;
        if (!rst_n)
        begin
            clear_scan();
            class_results_due.delete();
            mismatches     = 0;
            pieces_checked = 0;
            codes_hit      = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                scan_text_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = utf8sc_pkg::result_t'(m_axis_tdata);
                if (class_results_due.size() == 0)
                    report_mismatch("result beat with no piece awaiting it, tdata",
                                    int'(m_axis_tdata), 0);
                else
                begin
                    want = class_results_due.pop_front();
                    if (got.class_code != want.class_code)
                        report_mismatch("class_code", int'(got.class_code),
                                        int'(want.class_code));
                    if (got.latin_seen != want.latin_seen)
                        report_mismatch("latin_seen", int'(got.latin_seen),
                                        int'(want.latin_seen));
                    if (got.cyrillic_seen != want.cyrillic_seen)
                        report_mismatch("cyrillic_seen", int'(got.cyrillic_seen),
                                        int'(want.cyrillic_seen));
                    if (got.other_seen != want.other_seen)
                        report_mismatch("other_seen", int'(got.other_seen),
                                        int'(want.other_seen));
                    if (got.pad != 2'd0)
                        report_mismatch("padding bits", int'(got.pad), 0);
                    pieces_checked++;
                end
            end
        end
        results_due = class_results_due.size();
    end

endmodule

/* tb/tb_utf8_script_classifier.sv */
module tb_utf8_script_classifier;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DIRECTED_LEN = 27;

    // Directed pieces, each entry {last, byte}.
    localparam logic [8:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
        {1'b1, 8'h00},                                  // lowest byte, class none
        {1'b1, 8'h20},                                  // space only
        {1'b1, 8'h41},
        {1'b0, 8'h20}, {1'b0, 8'hD0}, {1'b1, 8'h90},    // space then Cyrillic
        {1'b0, 8'hD1}, {1'b0, 8'h80}, {1'b1, 8'h61},    // Latin beats Cyrillic
        {1'b0, 8'h20}, {1'b0, 8'h5A}, {1'b0, 8'hD1}, {1'b1, 8'h91},
        {1'b0, 8'hD0}, {1'b1, 8'h7F},                   // lead with a non-Cyrillic byte
        {1'b1, 8'hD1},                                  // lone lead as the final byte
        {1'b1, 8'hE3},                                  // sequence cut short
        {1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b0, 8'h98}, {1'b1, 8'h80},
        {1'b0, 8'hC3}, {1'b0, 8'hA9}, {1'b1, 8'hFF},
        {1'b0, 8'h20}, {1'b0, 8'h61}, {1'b1, 8'hE2}     // space, other beats Latin
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    int         mismatches;
    int         results_due;
    int         pieces_checked;
    logic [6:0] codes_hit;

    int         bytes_sent = 0;
    int         pieces_sent = 0;
    int         burst_left = 0;
    int         cycle_count = 0;
    logic       long_hold = 1'b0;
    logic [7:0] piece_bytes[$];

    utf8_script_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    utf8sc_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatches     (mismatches),
        .results_due    (results_due),
        .pieces_checked (pieces_checked),
        .codes_hit      (codes_hit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, results_due);
            $display("Verification failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        if (fin)
            pieces_sent++;
        @(negedge clk);
    endtask

    // One piece of mostly well-formed UTF-8, sometimes broken or cut short.
    task automatic build_piece();
        int tokens;
        int pick;
        int keep;
        piece_bytes.delete();
        if ($urandom_range(0, 9) < 3)
            piece_bytes.push_back(utf8sc_pkg::BYTE_SPACE);
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        repeat (tokens)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                piece_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                                           : 8'($urandom_range(8'h61, 8'h7A)));
            else if (pick < 40)
                piece_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
            else if (pick < 45)
                piece_bytes.push_back(utf8sc_pkg::BYTE_SPACE);
            else if (pick < 55)
            begin
                piece_bytes.push_back(utf8sc_pkg::BYTE_D0);
                piece_bytes.push_back($urandom_range(0, 7) == 0 ? utf8sc_pkg::BYTE_81
                                      : 8'($urandom_range(8'h90, 8'hBF)));
            end
            else if (pick < 65)
            begin
                piece_bytes.push_back(utf8sc_pkg::BYTE_D1);
                piece_bytes.push_back($urandom_range(0, 7) == 0 ? utf8sc_pkg::BYTE_91
                                      : 8'($urandom_range(8'h80, 8'h8F)));
            end
            else if (pick < 70)
            begin
                piece_bytes.push_back($urandom_range(0, 1) ? utf8sc_pkg::BYTE_D0
                                                           : utf8sc_pkg::BYTE_D1);
                piece_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick < 80)
            begin
                piece_bytes.push_back(8'($urandom_range(8'hC3, 8'hE2)));
                piece_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (pick < 87)
            begin
                piece_bytes.push_back(8'($urandom_range(8'hE3, 8'hEF)));
                repeat (2) piece_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (pick < 92)
            begin
                piece_bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
                repeat (3) piece_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            else
                piece_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 6) == 0)
        begin
            keep = $urandom_range(1, piece_bytes.size());
            while (piece_bytes.size() > keep)
                void'(piece_bytes.pop_back());
        end
    endtask

    // Receiver: switches at random between four stall behaviours.
    initial
    begin
        int          mode;
        int          mode_left;
        logic [15:0] pattern;
        logic        rdy;
        mode_left = 0;
        mode = 0;
        pattern = 16'hFFFF;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
                pattern = 16'($urandom) | 16'h0001;
            end
            mode_left--;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2:
                begin
                    rdy = pattern[0];
                    pattern = {pattern[0], pattern[15:1]};
                end
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            m_axis_tready <= long_hold ? 1'b0 : rdy;
        end
    end

    // Long back-pressure stretch partway through, so the input side fills and stalls.
    initial
    begin
        wait (bytes_sent >= 700);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        int i;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIRECTED_LEN; i++)
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

        while (bytes_sent < BYTE_TARGET)
        begin
            build_piece();
            for (i = 0; i < piece_bytes.size(); i++)
                send_byte(piece_bytes[i], i == piece_bytes.size() - 1);
        end
        s_axis_tvalid <= 1'b0;

        wait (results_due == 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d pieces; %0d results checked, %0d mismatches.",
                 bytes_sent, pieces_sent, pieces_checked, mismatches);
        $display("Class codes reached (code 6 down to 0): %b", codes_hit);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
